FILE: rtl/glcd_pixel_shadow_engine_defines.svh
// ----------------------------------------------------------------------------
// glcd_pixel_shadow_engine_defines
// Assertion macros used by the shadow engine top level. They expect the signals
// clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef GLCD_PIXEL_SHADOW_ENGINE_DEFINES_SVH
`define GLCD_PIXEL_SHADOW_ENGINE_DEFINES_SVH

// same-cycle implication
`define GPSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GPSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gpse_pkg.sv
// ----------------------------------------------------------------------------
// gpse_pkg
// Command and bus codes, controller/datapath interface types and the
// elaboration-time quotient/remainder table builder.
// ----------------------------------------------------------------------------
`default_nettype none

package gpse_pkg;

	typedef enum logic [2:0] {
		CMD_SET   = 3'd0,
		CMD_CLR   = 3'd1,
		CMD_HALF  = 3'd2,
		CMD_PAGE  = 3'd3,
		CMD_COL   = 3'd4,
		CMD_WRITE = 3'd5,
		CMD_READ  = 3'd6,
		CMD_NONE  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_HALF = 3'd0,
		KIND_PAGE = 3'd1,
		KIND_COL  = 3'd2,
		KIND_DATA = 3'd3,
		KIND_READ = 3'd4
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic       clear;
		logic       accept;
		logic       check;
		logic       emit;
		logic [1:0] idx;
		logic       last;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic out_free;
		logic has_res;
		logic four_res;
	} dp_stat_t;

	// entry v holds {v / div, v % div}, each 8 bits
	typedef logic [255:0][15:0] divmod_tab_t;

	function automatic divmod_tab_t divmod_table(input int unsigned div);
		divmod_tab_t tab;
		int unsigned q;
		int unsigned r;
		q = 0;
		r = 0;
		for (int v = 0; v < 256; v++) begin
			tab[v] = {q[7:0], r[7:0]};
			r++;
			if (r == div) begin
				r = 0;
				q++;
			end
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gpse_ram.sv
// ----------------------------------------------------------------------------
// gpse_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

FILE: rtl/gpse_ctrl.sv
// ----------------------------------------------------------------------------
// gpse_ctrl
// Sequencer: clearing pass, input transaction, shadow lookup, result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module gpse_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire gpse_pkg::dp_stat_t    stat,
	output gpse_pkg::ctrl_cmd_t        cmd
);

	import gpse_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] idx_q;
	logic [1:0] last_idx_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = stat.has_res ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				cmd.idx  = idx_q;
				cmd.last = (idx_q == last_idx_q);
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (cmd.last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.check) begin
				idx_q      <= '0;
				last_idx_q <= stat.four_res ? 2'd3 : 2'd0;
			end else if (cmd.emit) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/gpse_dp.sv
// ----------------------------------------------------------------------------
// gpse_dp
// Datapath: coordinate split, cursor, shadow RAM read-modify-write and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpse_dp #(
	parameter int HALF_COLUMNS = 64,
	parameter int PAGES        = 8,
	parameter int HALVES       = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gpse_pkg::ctrl_cmd_t cmd,
	output gpse_pkg::dp_stat_t       stat,
	input  wire gpse_pkg::cmd_t      in_cmd,
	input  wire logic [6:0]          in_x,
	input  wire logic [5:0]          in_y,
	input  wire logic [7:0]          in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output gpse_pkg::kind_t          out_kind,
	output logic [7:0]               out_value,
	output logic                     out_last
);

	import gpse_pkg::*;

	localparam int HW    = (HALVES > 1) ? $clog2(HALVES) : 1;
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int CW    = $clog2(HALF_COLUMNS);
	localparam int AW    = HW + PW + CW;
	localparam int DEPTH = 2 ** AW;
	localparam int ROWS  = PAGES * 8;
	localparam int RW    = $clog2(ROWS);
	localparam int unsigned X_LIMIT = HALVES * HALF_COLUMNS;

	localparam logic [RW-1:0] ROW_TOP  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST = CW'(HALF_COLUMNS - 1);

	localparam divmod_tab_t COL_TAB  = divmod_table(HALF_COLUMNS);
	localparam divmod_tab_t PAGE_TAB = divmod_table(PAGES);
	localparam divmod_tab_t HALF_TAB = divmod_table(HALVES);

	function automatic logic [CW-1:0] col_next(input logic [CW-1:0] c);
		return (c == COL_LAST) ? '0 : c + 1'b1;
	endfunction

	// input decode
	logic [15:0]   x_dm;
	logic [RW-1:0] row;
	logic          in_pix;
	logic          in_pix_ok;
	logic [HW-1:0] in_half;
	logic [PW-1:0] in_page;
	logic [CW-1:0] in_col;

	// item registers
	cmd_t          cmd_q;
	logic          pix_ok_q;
	logic [2:0]    bit_q;
	logic [7:0]    data_q;
	logic [HW-1:0] t_half_q;
	logic [PW-1:0] t_page_q;
	logic [CW-1:0] t_col_q;
	logic [7:0]    val_q;

	// cursor
	logic [HW-1:0] cur_half_q;
	logic [PW-1:0] cur_page_q;
	logic [CW-1:0] cur_col_q;

	// clearing pass
	logic [AW-1:0] clr_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	// lookup result
	logic          is_pix_q;
	logic [7:0]    mask;
	logic          bit_set;
	logic          pix_chg;
	logic [7:0]    new_byte;

	// output register
	logic          out_valid_q;
	kind_t         out_kind_q;
	logic [7:0]    out_value_q;
	logic          out_last_q;
	kind_t         emit_kind;
	logic [7:0]    emit_value;

	always_comb begin
		x_dm      = COL_TAB[{1'b0, in_x}];
		row       = ROW_TOP - RW'(in_y);
		in_pix    = (in_cmd == CMD_SET) || (in_cmd == CMD_CLR);
		in_pix_ok = (32'(in_x) < X_LIMIT) && (32'(in_y) < ROWS);
		if (in_pix) begin
			in_half = HW'(x_dm[15:8]);
			in_page = PW'(row >> 3);
			in_col  = CW'(x_dm[7:0]);
		end else begin
			in_half = HW'(HALF_TAB[in_data][7:0]);
			in_page = PW'(PAGE_TAB[in_data][7:0]);
			in_col  = CW'(COL_TAB[in_data][7:0]);
		end
	end

	always_comb begin
		is_pix_q = (cmd_q == CMD_SET) || (cmd_q == CMD_CLR);
		mask     = 8'h01 << bit_q;
		bit_set  = |(ram_rdata & mask);
		pix_chg  = pix_ok_q && ((cmd_q == CMD_SET) ? !bit_set : bit_set);
		new_byte = (cmd_q == CMD_SET) ? (ram_rdata | mask) : (ram_rdata & ~mask);
	end

	always_comb begin
		stat.clear_done = (clr_q == '1);
		stat.out_free   = !out_valid_q || out_ready;
		stat.four_res   = is_pix_q && pix_chg;
		case (cmd_q) inside
			CMD_SET, CMD_CLR:                         stat.has_res = pix_chg;
			CMD_HALF, CMD_PAGE, CMD_COL, CMD_WRITE, CMD_READ: stat.has_res = 1'b1;
			default:                                  stat.has_res = 1'b0;
		endcase
	end

	// single RAM port: clear, lookup on accept, write-back on check
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = is_pix_q ? new_byte : data_q;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = '0;
		end else if (cmd.check) begin
			ram_we   = (is_pix_q && pix_chg) || (cmd_q == CMD_WRITE);
			ram_addr = is_pix_q ? {t_half_q, t_page_q, t_col_q}
			                    : {cur_half_q, cur_page_q, cur_col_q};
		end else if (in_pix) begin
			ram_addr = {in_half, in_page, in_col};
		end else begin
			ram_addr = {cur_half_q, cur_page_q, cur_col_q};
		end
	end

	gpse_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q    <= in_cmd;
			pix_ok_q <= in_pix_ok;
			bit_q    <= row[2:0];
			data_q   <= in_data;
			t_half_q <= in_half;
			t_page_q <= in_page;
			t_col_q  <= in_col;
		end
		if (cmd.check) begin
			if (cmd_q == CMD_READ) begin
				val_q <= ram_rdata;
			end else begin
				val_q <= is_pix_q ? new_byte : data_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_half_q <= '0;
			cur_page_q <= '0;
			cur_col_q  <= '0;
			clr_q      <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.check) begin
				case (cmd_q) inside
					CMD_SET, CMD_CLR: begin
						if (pix_chg) begin
							cur_half_q <= t_half_q;
							cur_page_q <= t_page_q;
							cur_col_q  <= col_next(t_col_q);
						end
					end
					CMD_HALF:  cur_half_q <= t_half_q;
					CMD_PAGE:  cur_page_q <= t_page_q;
					CMD_COL:   cur_col_q  <= t_col_q;
					CMD_WRITE: cur_col_q  <= col_next(cur_col_q);
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		emit_kind  = KIND_DATA;
		emit_value = val_q;
		case (cmd_q) inside
			CMD_SET, CMD_CLR: begin
				case (cmd.idx)
					2'd0: begin
						emit_kind  = KIND_HALF;
						emit_value = 8'(t_half_q);
					end
					2'd1: begin
						emit_kind  = KIND_PAGE;
						emit_value = 8'(t_page_q);
					end
					2'd2: begin
						emit_kind  = KIND_COL;
						emit_value = 8'(t_col_q);
					end
					default: begin
						emit_kind  = KIND_DATA;
						emit_value = val_q;
					end
				endcase
			end
			CMD_HALF: begin
				emit_kind  = KIND_HALF;
				emit_value = 8'(t_half_q);
			end
			CMD_PAGE: begin
				emit_kind  = KIND_PAGE;
				emit_value = 8'(t_page_q);
			end
			CMD_COL: begin
				emit_kind  = KIND_COL;
				emit_value = 8'(t_col_q);
			end
			CMD_READ:  emit_kind = KIND_READ;
			default:   emit_kind = KIND_DATA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q  <= emit_kind;
			out_value_q <= emit_value;
			out_last_q  <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/glcd_pixel_shadow_engine.sv
// ----------------------------------------------------------------------------
// glcd_pixel_shadow_engine
// Shadow framebuffer and bus transaction sequencer for a paged monochrome
// graphic LCD.
// ----------------------------------------------------------------------------
// The block keeps a copy of the panel (HALVES halves of PAGES pages of
// HALF_COLUMNS column bytes) in one single-port RAM, plus a cursor. Items are
// handled one at a time; each goes through the RAM port once for lookup and
// once for write-back, and results leave through a single output register.
// With the output side always ready, a pixel set or clear that changes the
// bit passes through the transaction, the lookup and four bus transactions
// (half select, page address, column address, data write); a pixel that
// already holds the value, one off the panel, or the none command passes
// through the transaction and the lookup only; every other raw command adds
// one bus transaction after the lookup. Output stalls hold the sequence, but
// the next input is taken while the final result of an item still waits.
// After reset the RAM is cleared one entry per cycle over all its addresses
// (1024 entries with the defaults); no input is taken until that pass ends.
`default_nettype none

`include "glcd_pixel_shadow_engine_defines.svh"

module glcd_pixel_shadow_engine #(
	parameter int HALF_COLUMNS = 64,
	parameter int PAGES        = 8,
	parameter int HALVES       = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // pixel_x[6:0], pixel_y[12:7], data_byte[20:13], zero
	input  wire logic [2:0]  s_tuser,   // command[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // bus_value[7:0]
	output logic [2:0]       m_tuser,   // bus_kind[2:0]
	output logic             m_tlast
);

	import gpse_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	kind_t     out_kind;
	cmd_t      in_cmd;

	assign in_cmd = cmd_t'(s_tuser);

	gpse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gpse_dp #(
		.HALF_COLUMNS (HALF_COLUMNS),
		.PAGES        (PAGES),
		.HALVES       (HALVES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_cmd    (in_cmd),
		.in_x      (s_tdata[6:0]),
		.in_y      (s_tdata[12:7]),
		.in_data   (s_tdata[20:13]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (out_kind),
		.out_value (m_tdata),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_kind;

	// a new item only enters when any pending result closes the previous item
	`GPSE_ASSERT_NOW(a_ready_after_last, s_tready, !m_tvalid || m_tlast,
		"input taken while a non-final result is pending")
	// an accepted item always gets its lookup cycle
	`GPSE_ASSERT_NEXT(a_lookup_after_accept, s_tvalid && s_tready, cmd.check && !s_tready,
		"lookup cycle missing after input transaction")
	// never overwrite a result that has not been taken
	`GPSE_ASSERT_NOW(a_emit_into_free, cmd.emit, !m_tvalid || m_tready,
		"result loaded over a pending result")

endmodule

`default_nettype wire
